>>> sv/acscu_pkg.sv
// ----------------------------------------------------------------------------
// Alarm clock setting controller package
// Shared types, register indexes, codes and reset values of the controller.
// ----------------------------------------------------------------------------
`default_nettype none

package acscu_pkg;

    // Width of every configuration register and of the write port.
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int TIMER_W_DEF = 16;

    // Field widths of one tick and one result.
    localparam int BTN_W  = 5;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;

    // Button bit positions within the buttons field.
    localparam int KEY_SELECT = 0;
    localparam int KEY_UP     = 1;
    localparam int KEY_DOWN   = 2;
    localparam int KEY_LEFT   = 3;
    localparam int KEY_RIGHT  = 4;

    // Largest hour and minute values; adjusting wraps around them.
    localparam logic [HOUR_W-1:0] HOUR_LAST = HOUR_W'(23);
    localparam logic [MIN_W-1:0]  MIN_LAST  = MIN_W'(59);

    // Reset values of the stored alarm time.
    localparam logic [HOUR_W-1:0] ALARM_HOUR_RST   = HOUR_W'(8);
    localparam logic [MIN_W-1:0]  ALARM_MINUTE_RST = MIN_W'(0);

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] HOLD_TICKS_RST   = CFG_W'(1000);
    localparam logic [CFG_W-1:0] REPEAT_TICKS_RST = CFG_W'(100);
    localparam logic [CFG_W-1:0] IDLE_TICKS_RST   = CFG_W'(5000);
    localparam logic [CFG_W-1:0] BLINK_TICKS_RST  = CFG_W'(500);
    localparam logic [CFG_W-1:0] COLON_TICKS_RST  = CFG_W'(1000);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD_TICKS   = 3'd0,
        CFG_REPEAT_TICKS = 3'd1,
        CFG_IDLE_TICKS   = 3'd2,
        CFG_BLINK_TICKS  = 3'd3,
        CFG_COLON_TICKS  = 3'd4
    } cfg_idx_t;

    // Menu modes.
    typedef enum logic [1:0] {
        MODE_CLOCK    = 2'd0,
        MODE_ALARM    = 2'd1,
        MODE_SET_HOUR = 2'd2,
        MODE_SET_MIN  = 2'd3
    } mode_t;

    // Current configuration as seen by the core.
    typedef struct packed {
        logic [CFG_W-1:0] hold_ticks;
        logic [CFG_W-1:0] repeat_ticks;
        logic [CFG_W-1:0] idle_ticks;
        logic [CFG_W-1:0] blink_ticks;
        logic [CFG_W-1:0] colon_ticks;
    } cfg_t;

    // One millisecond tick.
    typedef struct packed {
        logic [BTN_W-1:0]  buttons;
        logic [HOUR_W-1:0] now_hour;
        logic [MIN_W-1:0]  now_minute;
        logic              wake;
    } tick_t;

    // One display result.
    typedef struct packed {
        mode_t             mode;
        logic              awake;
        logic              ringing;
        logic [HOUR_W-1:0] shown_hour;
        logic [MIN_W-1:0]  shown_minute;
        logic              hour_visible;
        logic              minute_visible;
        logic              colon_on;
        logic [HOUR_W-1:0] alarm_hour_out;
        logic [MIN_W-1:0]  alarm_minute_out;
    } result_t;

    // Handshake between the input stage and the core.
    typedef struct packed {
        logic  valid;
        tick_t data;
    } tick_beat_t;

endpackage

`default_nettype wire

>>> sv/acscu_in_if.sv
// ----------------------------------------------------------------------------
// Tick channel interface
// Valid/ready channel that carries one millisecond tick per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface acscu_in_if;
    logic       valid;
    logic       ready;
    logic [4:0] buttons;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic       wake;

    modport source (output valid, buttons, now_hour, now_minute, wake, input ready);
    modport sink   (input valid, buttons, now_hour, now_minute, wake, output ready);
endinterface

`default_nettype wire

>>> sv/acscu_out_if.sv
// ----------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel that carries one display result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface acscu_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic       awake;
    logic       ringing;
    logic [4:0] shown_hour;
    logic [5:0] shown_minute;
    logic       hour_visible;
    logic       minute_visible;
    logic       colon_on;
    logic [4:0] alarm_hour_out;
    logic [5:0] alarm_minute_out;

    modport source (
        output valid, mode, awake, ringing, shown_hour, shown_minute,
               hour_visible, minute_visible, colon_on, alarm_hour_out,
               alarm_minute_out,
        input  ready
    );
    modport sink (
        input  valid, mode, awake, ringing, shown_hour, shown_minute,
               hour_visible, minute_visible, colon_on, alarm_hour_out,
               alarm_minute_out,
        output ready
    );
endinterface

`default_nettype wire

>>> sv/acscu_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the five timing registers written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module acscu_cfg
    import acscu_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; indexes past the list are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_HOLD_TICKS:   cfg_next.hold_ticks   = cfg_wdata;
                CFG_REPEAT_TICKS: cfg_next.repeat_ticks = cfg_wdata;
                CFG_IDLE_TICKS:   cfg_next.idle_ticks   = cfg_wdata;
                CFG_BLINK_TICKS:  cfg_next.blink_ticks  = cfg_wdata;
                CFG_COLON_TICKS:  cfg_next.colon_ticks  = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_ticks   <= HOLD_TICKS_RST;
            cfg_reg.repeat_ticks <= REPEAT_TICKS_RST;
            cfg_reg.idle_ticks   <= IDLE_TICKS_RST;
            cfg_reg.blink_ticks  <= BLINK_TICKS_RST;
            cfg_reg.colon_ticks  <= COLON_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> sv/acscu_in_stage.sv
// ----------------------------------------------------------------------------
// Tick input register
// Captures one tick beat and holds it until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module acscu_in_stage
    import acscu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    acscu_in_if.sink   tick,
    input  wire logic  take,
    output tick_beat_t beat
);

    logic  valid_reg;
    logic  valid_next;
    tick_t data_reg;
    logic  accept;

    // Room for a new beat when empty or when the held one leaves this cycle.
    assign tick.ready = !valid_reg || take;
    assign accept     = tick.valid && tick.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg.buttons    <= tick.buttons;
            data_reg.now_hour   <= tick.now_hour;
            data_reg.now_minute <= tick.now_minute;
            data_reg.wake       <= tick.wake;
        end
    end

    assign beat.valid = valid_reg;
    assign beat.data  = data_reg;

endmodule

`default_nettype wire

>>> sv/acscu_core.sv
// ----------------------------------------------------------------------------
// Controller core
// Menu, alarm, button and timer state; one tick is processed per cycle and
// its result is written into the output register; a result not yet taken stalls the ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module acscu_core
    import acscu_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_W_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire tick_beat_t beat,
    output logic            take,
    acscu_out_if.source     status
);

    localparam int TW = TIMER_WIDTH;
    localparam int CW = (TW > CFG_W) ? TW : CFG_W;
    localparam logic [TW-1:0] TMAX = {TW{1'b1}};

    // State registers.
    mode_t             mode_reg, mode_next;
    logic [HOUR_W-1:0] alarm_hour_reg, alarm_hour_next;
    logic [MIN_W-1:0]  alarm_minute_reg, alarm_minute_next;
    logic [BTN_W-1:0]  prev_reg, prev_next;
    logic [TW-1:0]     since_press_reg, since_press_next;
    logic [TW-1:0]     since_rep_reg, since_rep_next;
    logic [TW-1:0]     blink_timer_reg, blink_timer_next;
    logic [TW-1:0]     colon_timer_reg, colon_timer_next;
    logic              blink_phase_reg, blink_phase_next;
    logic              colon_phase_reg, colon_phase_next;
    logic              fired_reg, fired_next;
    logic              ring_reg, ring_next;
    logic              awake_reg, awake_next;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    result_t           result_reg, result_next;

    // Working values.
    tick_t             tk;
    logic              match;
    logic              ring_tick;
    logic              changed;
    logic [BTN_W-1:0]  edges;
    logic [BTN_W-1:0]  autop;

    assign tk   = beat.data;
    assign take = beat.valid && (!out_valid_reg || status.ready);

    // Tick processing: alarm check, then wake, ringing or awake update.
    always_comb
    begin
        mode_next         = mode_reg;
        alarm_hour_next   = alarm_hour_reg;
        alarm_minute_next = alarm_minute_reg;
        prev_next         = prev_reg;
        since_press_next  = since_press_reg;
        since_rep_next    = since_rep_reg;
        blink_timer_next  = blink_timer_reg;
        colon_timer_next  = colon_timer_reg;
        blink_phase_next  = blink_phase_reg;
        colon_phase_next  = colon_phase_reg;
        fired_next        = fired_reg;
        ring_next         = ring_reg;
        awake_next        = awake_reg;
        ring_tick         = 1'b0;
        changed           = 1'b0;
        edges             = '0;
        autop             = '0;
        match = (alarm_hour_reg == tk.now_hour) && (alarm_minute_reg == tk.now_minute);

        if (take)
        begin
            // Alarm check runs on every tick, asleep or awake.
            if (ring_reg)
            begin
                ring_tick = 1'b1;
                if (tk.buttons[KEY_SELECT])
                begin
                    ring_next  = 1'b0;
                    fired_next = 1'b1;
                end
            end
            else if (match)
            begin
                if (mode_reg != MODE_SET_HOUR && mode_reg != MODE_SET_MIN && !fired_reg)
                begin
                    ring_next = 1'b1;
                    ring_tick = 1'b1;
                end
            end
            else
            begin
                fired_next = 1'b0;
            end

            if (ring_tick)
            begin
                // While ringing only the button levels are tracked.
                if (awake_reg)
                begin
                    prev_next = tk.buttons;
                end
            end
            else if (!awake_reg)
            begin
                if (tk.wake)
                begin
                    awake_next       = 1'b1;
                    mode_next        = MODE_CLOCK;
                    prev_next        = '0;
                    since_press_next = '0;
                    since_rep_next   = TMAX;
                    blink_timer_next = TMAX;
                    colon_timer_next = TMAX;
                    blink_phase_next = 1'b0;
                    colon_phase_next = 1'b0;
                end
            end
            else
            begin
                // Saturating timers.
                since_press_next = (since_press_reg == TMAX) ? TMAX
                                 : since_press_reg + TW'(1);
                since_rep_next   = (since_rep_reg == TMAX) ? TMAX
                                 : since_rep_reg + TW'(1);
                blink_timer_next = (blink_timer_reg == TMAX) ? TMAX
                                 : blink_timer_reg + TW'(1);
                colon_timer_next = (colon_timer_reg == TMAX) ? TMAX
                                 : colon_timer_reg + TW'(1);

                // Blink and colon phases.
                if (CW'(blink_timer_next) >= CW'(cfg.blink_ticks))
                begin
                    blink_timer_next = '0;
                    blink_phase_next = !blink_phase_reg;
                end
                if (CW'(colon_timer_next) >= CW'(cfg.colon_ticks))
                begin
                    colon_timer_next = '0;
                    colon_phase_next = !colon_phase_reg;
                end

                // Rising edges and hold-to-repeat.
                edges = tk.buttons & ~prev_reg;
                if (edges != '0)
                begin
                    since_press_next = '0;
                end
                autop = edges;
                if (tk.buttons != '0
                    && CW'(since_press_next) > CW'(cfg.hold_ticks)
                    && CW'(since_rep_next) > CW'(cfg.repeat_ticks))
                begin
                    autop          = autop | tk.buttons;
                    since_rep_next = '0;
                end
                prev_next = tk.buttons;

                // Menu keys: middle, then right, then left.
                if (edges[KEY_SELECT])
                begin
                    case (mode_reg)
                        MODE_ALARM:    mode_next = MODE_SET_HOUR;
                        MODE_SET_HOUR: mode_next = MODE_SET_MIN;
                        MODE_SET_MIN:  mode_next = MODE_ALARM;
                        default:       mode_next = mode_reg;
                    endcase
                end
                else if (edges[KEY_RIGHT])
                begin
                    case (mode_reg)
                        MODE_CLOCK:    mode_next = MODE_ALARM;
                        MODE_SET_HOUR: mode_next = MODE_SET_MIN;
                        default:       mode_next = mode_reg;
                    endcase
                end
                else if (edges[KEY_LEFT])
                begin
                    case (mode_reg)
                        MODE_ALARM:   mode_next = MODE_CLOCK;
                        MODE_SET_MIN: mode_next = MODE_SET_HOUR;
                        default:      mode_next = mode_reg;
                    endcase
                end
                changed = (mode_next != mode_reg);

                // Up and down adjust the alarm time with wraparound.
                if (autop[KEY_UP])
                begin
                    if (mode_next == MODE_SET_HOUR)
                    begin
                        alarm_hour_next = (alarm_hour_reg >= HOUR_LAST) ? '0
                                        : alarm_hour_reg + HOUR_W'(1);
                        changed = 1'b1;
                    end
                    else if (mode_next == MODE_SET_MIN)
                    begin
                        alarm_minute_next = (alarm_minute_reg >= MIN_LAST) ? '0
                                          : alarm_minute_reg + MIN_W'(1);
                        changed = 1'b1;
                    end
                end
                else if (autop[KEY_DOWN])
                begin
                    if (mode_next == MODE_SET_HOUR)
                    begin
                        alarm_hour_next = (alarm_hour_reg == '0 || alarm_hour_reg > HOUR_LAST)
                                        ? HOUR_LAST : alarm_hour_reg - HOUR_W'(1);
                        changed = 1'b1;
                    end
                    else if (mode_next == MODE_SET_MIN)
                    begin
                        alarm_minute_next = (alarm_minute_reg == '0 || alarm_minute_reg > MIN_LAST)
                                          ? MIN_LAST : alarm_minute_reg - MIN_W'(1);
                        changed = 1'b1;
                    end
                end

                // A change restarts the phase that is on show.
                if (changed)
                begin
                    if (mode_next == MODE_CLOCK)
                    begin
                        colon_phase_next = 1'b0;
                        colon_timer_next = TMAX;
                    end
                    else if (mode_next == MODE_SET_HOUR || mode_next == MODE_SET_MIN)
                    begin
                        blink_phase_next = 1'b0;
                        blink_timer_next = TMAX;
                    end
                end

                // Idle timeout in clock mode.
                if (mode_next == MODE_CLOCK && CW'(since_press_next) >= CW'(cfg.idle_ticks))
                begin
                    awake_next = 1'b0;
                    prev_next  = '0;
                end
            end
        end
    end

    // Result from the updated state.
    always_comb
    begin
        result_next.mode             = mode_next;
        result_next.awake            = awake_next;
        result_next.ringing          = ring_next;
        result_next.alarm_hour_out   = alarm_hour_next;
        result_next.alarm_minute_out = alarm_minute_next;
        if (!awake_next)
        begin
            result_next.shown_hour     = '0;
            result_next.shown_minute   = '0;
            result_next.hour_visible   = 1'b0;
            result_next.minute_visible = 1'b0;
            result_next.colon_on       = 1'b0;
        end
        else if (mode_next == MODE_CLOCK)
        begin
            result_next.shown_hour     = tk.now_hour;
            result_next.shown_minute   = tk.now_minute;
            result_next.hour_visible   = 1'b1;
            result_next.minute_visible = 1'b1;
            result_next.colon_on       = colon_phase_next;
        end
        else
        begin
            result_next.shown_hour     = alarm_hour_next;
            result_next.shown_minute   = alarm_minute_next;
            result_next.hour_visible   = (mode_next == MODE_SET_HOUR) ? blink_phase_next : 1'b1;
            result_next.minute_visible = (mode_next == MODE_SET_MIN) ? blink_phase_next : 1'b1;
            result_next.colon_on       = 1'b1;
        end
    end

    // Output register fills on a take and empties when the beat is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_CLOCK;
            alarm_hour_reg   <= ALARM_HOUR_RST;
            alarm_minute_reg <= ALARM_MINUTE_RST;
            prev_reg         <= '0;
            since_press_reg  <= '0;
            since_rep_reg    <= '0;
            blink_timer_reg  <= '0;
            colon_timer_reg  <= '0;
            blink_phase_reg  <= 1'b0;
            colon_phase_reg  <= 1'b0;
            fired_reg        <= 1'b0;
            ring_reg         <= 1'b0;
            awake_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            mode_reg         <= mode_next;
            alarm_hour_reg   <= alarm_hour_next;
            alarm_minute_reg <= alarm_minute_next;
            prev_reg         <= prev_next;
            since_press_reg  <= since_press_next;
            since_rep_reg    <= since_rep_next;
            blink_timer_reg  <= blink_timer_next;
            colon_timer_reg  <= colon_timer_next;
            blink_phase_reg  <= blink_phase_next;
            colon_phase_reg  <= colon_phase_next;
            fired_reg        <= fired_next;
            ring_reg         <= ring_next;
            awake_reg        <= awake_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

    assign status.valid            = out_valid_reg;
    assign status.mode             = result_reg.mode;
    assign status.awake            = result_reg.awake;
    assign status.ringing          = result_reg.ringing;
    assign status.shown_hour       = result_reg.shown_hour;
    assign status.shown_minute     = result_reg.shown_minute;
    assign status.hour_visible     = result_reg.hour_visible;
    assign status.minute_visible   = result_reg.minute_visible;
    assign status.colon_on         = result_reg.colon_on;
    assign status.alarm_hour_out   = result_reg.alarm_hour_out;
    assign status.alarm_minute_out = result_reg.alarm_minute_out;

    // The alarm never starts or keeps ringing in a set mode.
    a_ring_not_in_set: assert property (@(posedge clk) disable iff (!rst_n)
        ring_reg |-> (mode_reg == MODE_CLOCK || mode_reg == MODE_ALARM))
        else $error("alarm ringing in a set mode");

    // Asleep means clock mode with cleared button history.
    a_sleep_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !awake_reg |-> (mode_reg == MODE_CLOCK && prev_reg == '0))
        else $error("asleep with menu or button state left over");

    // State moves only when a tick is processed.
    a_hold_without_take: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> ($stable(mode_reg) && $stable(alarm_hour_reg)
                   && $stable(alarm_minute_reg) && $stable(ring_reg)
                   && $stable(awake_reg)))
        else $error("state changed without a processed tick");

    // The stored alarm time stays a valid time of day.
    a_alarm_range: assert property (@(posedge clk) disable iff (!rst_n)
        (alarm_hour_reg <= HOUR_LAST && alarm_minute_reg <= MIN_LAST))
        else $error("stored alarm time out of range");

endmodule

`default_nettype wire

>>> sv/alarm_clock_setting_controller_unit.sv
// ----------------------------------------------------------------------------
// Alarm clock setting controller
// Menu, alarm time, button repeat, blink and alarm ringing for a clock face.
// ----------------------------------------------------------------------------
// Usage:
//   tick   - one beat per millisecond: button levels, current hour and minute,
//            and a wake event. Sink side, valid/ready.
//   status - one display result per tick beat, in order. Source side.
//   cfg_*  - write port for the five timing registers; write while idle.
// Path: a tick beat accepted into the tick register is processed from there
//   and its result beat is written into the result register and offered.
// Throughput: one tick beat per cycle while status is not stalled. The whole
//   update of menu, timers and alarm for one tick is a single pass between
//   the tick register and the result register.
// Reset: clock mode, asleep, alarm at 08:00, timing registers at their
//   defaults, both channels empty.
// Stall: while status is stalled the result register holds its beat and the
//   tick register takes one more beat if it is empty, then tick.ready drops
//   until the result beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module alarm_clock_setting_controller_unit
    import acscu_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_W_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    acscu_in_if.sink                  tick,
    acscu_out_if.source               status,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    cfg_t       cfg;
    tick_beat_t beat;
    logic       take;

    // Timing registers.
    acscu_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Tick input register.
    acscu_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (tick),
        .take  (take),
        .beat  (beat)
    );

    // State update and result register.
    acscu_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .beat   (beat),
        .take   (take),
        .status (status)
    );

endmodule

`default_nettype wire

>>> dv/acscu_status_scoreboard.sv
// ----------------------------------------------------------------------------
// Alarm clock controller status scoreboard
// Watches the tick and status channels and the register write port. It keeps
// its own copy of the menu, alarm, button-repeat, blink and ringing state,
// works out the status beat that each accepted tick should produce, and
// compares every status beat, field by field, with the oldest one waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module acscu_status_scoreboard
    import acscu_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_W_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    acscu_in_if                       tick_bus,
    acscu_out_if                      status_bus,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    output int                        mismatches,
    output int                        outstanding,
    output int                        checked,
    output int                        ring_beats,
    output logic [HOUR_W-1:0]         alarm_hour_hint,
    output logic [MIN_W-1:0]          alarm_minute_hint,
    output logic                      awake_hint
);

    // Register copies, updated from the write port.
    logic [CFG_W-1:0] hold_cfg;
    logic [CFG_W-1:0] repeat_cfg;
    logic [CFG_W-1:0] idle_cfg;
    logic [CFG_W-1:0] blink_cfg;
    logic [CFG_W-1:0] colon_cfg;

    // Predicted controller state.
    mode_t                  menu;
    logic [HOUR_W-1:0]      al_hour;
    logic [MIN_W-1:0]       al_min;
    logic [BTN_W-1:0]       last_btn;
    logic [TIMER_WIDTH-1:0] press_age;
    logic [TIMER_WIDTH-1:0] repeat_age;
    logic [TIMER_WIDTH-1:0] blink_cnt;
    logic [TIMER_WIDTH-1:0] colon_cnt;
    logic                   blink_ph;
    logic                   colon_ph;
    logic                   fired;
    logic                   ring;
    logic                   powered;

    result_t expected_status [$];
    tick_t   seen_tick;
    result_t want;

    // Saturating timer increment.
    function automatic logic [TIMER_WIDTH-1:0] bump(input logic [TIMER_WIDTH-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // Advance the predicted state by one tick and return the status it shows.
    function automatic result_t advance_tick(input tick_t t);
        logic [BTN_W-1:0] rises;
        logic [BTN_W-1:0] acts;
        mode_t            old_mode;
        logic             match;
        logic             ring_tick;
        logic             touched;
        result_t          r;

        match     = (al_hour == t.now_hour) && (al_min == t.now_minute);
        ring_tick = 1'b0;

        // Alarm check runs on every tick, asleep or awake.
        if (ring)
        begin
            ring_tick = 1'b1;
            if (t.buttons[KEY_SELECT])
            begin
                ring  = 1'b0;
                fired = 1'b1;
            end
        end
        else if (match)
        begin
            if (menu != MODE_SET_HOUR && menu != MODE_SET_MIN && !fired)
            begin
                ring      = 1'b1;
                ring_tick = 1'b1;
            end
        end
        else
        begin
            fired = 1'b0;
        end

        if (ring_tick)
        begin
            // While ringing, only the button history moves.
            if (powered)
                last_btn = t.buttons;
        end
        else if (!powered)
        begin
            if (t.wake)
            begin
                powered    = 1'b1;
                menu       = MODE_CLOCK;
                last_btn   = '0;
                press_age  = '0;
                repeat_age = '1;
                blink_cnt  = '1;
                colon_cnt  = '1;
                blink_ph   = 1'b0;
                colon_ph   = 1'b0;
            end
        end
        else
        begin
            // Timers and phases.
            press_age  = bump(press_age);
            repeat_age = bump(repeat_age);
            blink_cnt  = bump(blink_cnt);
            colon_cnt  = bump(colon_cnt);
            if (blink_cnt >= blink_cfg)
            begin
                blink_cnt = '0;
                blink_ph  = ~blink_ph;
            end
            if (colon_cnt >= colon_cfg)
            begin
                colon_cnt = '0;
                colon_ph  = ~colon_ph;
            end

            // Rising edges, plus hold-to-repeat presses.
            rises = t.buttons & ~last_btn;
            if (rises != '0)
                press_age = '0;
            acts = rises;
            if (t.buttons != '0 && press_age > hold_cfg && repeat_age > repeat_cfg)
            begin
                acts       = acts | t.buttons;
                repeat_age = '0;
            end
            last_btn = t.buttons;

            // Menu keys: middle, then right, then left.
            old_mode = menu;
            if (rises[KEY_SELECT])
            begin
                case (menu)
                    MODE_ALARM:    menu = MODE_SET_HOUR;
                    MODE_SET_HOUR: menu = MODE_SET_MIN;
                    MODE_SET_MIN:  menu = MODE_ALARM;
                    default:       ;
                endcase
            end
            else if (rises[KEY_RIGHT])
            begin
                if (menu == MODE_CLOCK)
                    menu = MODE_ALARM;
                else if (menu == MODE_SET_HOUR)
                    menu = MODE_SET_MIN;
            end
            else if (rises[KEY_LEFT])
            begin
                if (menu == MODE_ALARM)
                    menu = MODE_CLOCK;
                else if (menu == MODE_SET_MIN)
                    menu = MODE_SET_HOUR;
            end
            touched = (menu != old_mode);

            // Up wins over down; both wrap around.
            if (acts[KEY_UP])
            begin
                if (menu == MODE_SET_HOUR)
                begin
                    al_hour = (al_hour >= HOUR_LAST) ? '0 : al_hour + 1'b1;
                    touched = 1'b1;
                end
                else if (menu == MODE_SET_MIN)
                begin
                    al_min  = (al_min >= MIN_LAST) ? '0 : al_min + 1'b1;
                    touched = 1'b1;
                end
            end
            else if (acts[KEY_DOWN])
            begin
                if (menu == MODE_SET_HOUR)
                begin
                    al_hour = (al_hour == '0 || al_hour > HOUR_LAST) ? HOUR_LAST
                                                                     : al_hour - 1'b1;
                    touched = 1'b1;
                end
                else if (menu == MODE_SET_MIN)
                begin
                    al_min  = (al_min == '0 || al_min > MIN_LAST) ? MIN_LAST : al_min - 1'b1;
                    touched = 1'b1;
                end
            end

            // A change restarts the phase of the current mode.
            if (touched)
            begin
                if (menu == MODE_CLOCK)
                begin
                    colon_ph  = 1'b0;
                    colon_cnt = '1;
                end
                else if (menu == MODE_SET_HOUR || menu == MODE_SET_MIN)
                begin
                    blink_ph  = 1'b0;
                    blink_cnt = '1;
                end
            end

            // Idle timeout in clock mode.
            if (menu == MODE_CLOCK && press_age >= idle_cfg)
            begin
                powered  = 1'b0;
                last_btn = '0;
            end
        end

        r                  = '0;
        r.mode             = menu;
        r.awake            = powered;
        r.ringing          = ring;
        r.alarm_hour_out   = al_hour;
        r.alarm_minute_out = al_min;
        if (powered && menu == MODE_CLOCK)
        begin
            r.shown_hour     = t.now_hour;
            r.shown_minute   = t.now_minute;
            r.hour_visible   = 1'b1;
            r.minute_visible = 1'b1;
            r.colon_on       = colon_ph;
        end
        else if (powered)
        begin
            r.shown_hour     = al_hour;
            r.shown_minute   = al_min;
            r.hour_visible   = (menu == MODE_SET_HOUR) ? blink_ph : 1'b1;
            r.minute_visible = (menu == MODE_SET_MIN) ? blink_ph : 1'b1;
            r.colon_on       = 1'b1;
        end
        return r;
    endfunction

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string msg);
        $display("[%0t] status mismatch: %s", $time, msg);
        mismatches = mismatches + 1;
    endtask

    task automatic compare_field(input string name, input int seen, input int wanted);
        if (seen != wanted)
            report_mismatch($sformatf("beat %0d %s got %0d, expected %0d",
                                      checked, name, seen, wanted));
    endtask

    // Predict on every accepted tick beat, compare on every status beat.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cfg   = HOLD_TICKS_RST;
            repeat_cfg = REPEAT_TICKS_RST;
            idle_cfg   = IDLE_TICKS_RST;
            blink_cfg  = BLINK_TICKS_RST;
            colon_cfg  = COLON_TICKS_RST;
            menu       = MODE_CLOCK;
            al_hour    = ALARM_HOUR_RST;
            al_min     = ALARM_MINUTE_RST;
            last_btn   = '0;
            press_age  = '0;
            repeat_age = '0;
            blink_cnt  = '0;
            colon_cnt  = '0;
            blink_ph   = 1'b0;
            colon_ph   = 1'b0;
            fired      = 1'b0;
            ring       = 1'b0;
            powered    = 1'b0;
            mismatches = 0;
            checked    = 0;
            ring_beats = 0;
            expected_status.delete();
            outstanding       <= 0;
            alarm_hour_hint   <= ALARM_HOUR_RST;
            alarm_minute_hint <= ALARM_MINUTE_RST;
            awake_hint        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HOLD_TICKS:   hold_cfg   = cfg_wdata;
                    CFG_REPEAT_TICKS: repeat_cfg = cfg_wdata;
                    CFG_IDLE_TICKS:   idle_cfg   = cfg_wdata;
                    CFG_BLINK_TICKS:  blink_cfg  = cfg_wdata;
                    CFG_COLON_TICKS:  colon_cfg  = cfg_wdata;
                    default:          ;
                endcase
            end

            if (tick_bus.valid && tick_bus.ready)
            begin
                seen_tick.buttons    = tick_bus.buttons;
                seen_tick.now_hour   = tick_bus.now_hour;
                seen_tick.now_minute = tick_bus.now_minute;
                seen_tick.wake       = tick_bus.wake;
                expected_status.push_back(advance_tick(seen_tick));
            end

            if (status_bus.valid && status_bus.ready)
            begin
                if (expected_status.size() == 0)
                begin
                    report_mismatch($sformatf("beat %0d arrived with no tick waiting",
                                              checked));
                end
                else
                begin
                    want = expected_status.pop_front();
                    compare_field("mode", int'(status_bus.mode), int'(want.mode));
                    compare_field("awake", int'(status_bus.awake), int'(want.awake));
                    compare_field("ringing", int'(status_bus.ringing), int'(want.ringing));
                    compare_field("shown_hour", int'(status_bus.shown_hour),
                                  int'(want.shown_hour));
                    compare_field("shown_minute", int'(status_bus.shown_minute),
                                  int'(want.shown_minute));
                    compare_field("hour_visible", int'(status_bus.hour_visible),
                                  int'(want.hour_visible));
                    compare_field("minute_visible", int'(status_bus.minute_visible),
                                  int'(want.minute_visible));
                    compare_field("colon_on", int'(status_bus.colon_on), int'(want.colon_on));
                    compare_field("alarm_hour_out", int'(status_bus.alarm_hour_out),
                                  int'(want.alarm_hour_out));
                    compare_field("alarm_minute_out", int'(status_bus.alarm_minute_out),
                                  int'(want.alarm_minute_out));
                    if (want.ringing)
                        ring_beats = ring_beats + 1;
                end
                checked = checked + 1;
            end

            outstanding       <= expected_status.size();
            alarm_hour_hint   <= al_hour;
            alarm_minute_hint <= al_min;
            awake_hint        <= powered;
        end
    end

endmodule

`default_nettype wire

>>> dv/tb_alarm_clock_setting_controller_unit.sv
// ----------------------------------------------------------------------------
// Alarm clock setting controller testbench
// Drives millisecond ticks into the controller: a short directed sequence
// through ringing, wake-up, menu moves and alarm wraparound, then random
// button holds, alarm-time matches and wake events under eight register
// settings, with random gaps and stalls on both channels. A scoreboard
// beside the block checks every status beat; this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_alarm_clock_setting_controller_unit
    import acscu_pkg::*;
();

    localparam int PHASES      = 8;
    localparam int PHASE_TICKS = 210;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_OFF    = 120;
    localparam int HOLD_OFF_AT = 500;

    localparam logic [BTN_W-1:0] B_MID   = BTN_W'(1) << KEY_SELECT;
    localparam logic [BTN_W-1:0] B_UP    = BTN_W'(1) << KEY_UP;
    localparam logic [BTN_W-1:0] B_DOWN  = BTN_W'(1) << KEY_DOWN;
    localparam logic [BTN_W-1:0] B_LEFT  = BTN_W'(1) << KEY_LEFT;
    localparam logic [BTN_W-1:0] B_RIGHT = BTN_W'(1) << KEY_RIGHT;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 steady;

    int                   mismatches;
    int                   outstanding;
    int                   checked;
    int                   ring_beats;
    logic [HOUR_W-1:0]    alarm_hour_hint;
    logic [MIN_W-1:0]     alarm_minute_hint;
    logic                 awake_hint;

    int                   ticks_sent;
    int                   quiet_cycles;
    logic [BTN_W-1:0]     cur_btn;
    logic [HOUR_W-1:0]    cur_hour;
    logic [MIN_W-1:0]     cur_min;

    acscu_in_if  tick_ch ();
    acscu_out_if status_ch ();

    alarm_clock_setting_controller_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .status    (status_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    acscu_status_scoreboard scoreboard (
        .clk               (clk),
        .rst_n             (rst_n),
        .tick_bus          (tick_ch),
        .status_bus        (status_ch),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .mismatches        (mismatches),
        .outstanding       (outstanding),
        .checked           (checked),
        .ring_beats        (ring_beats),
        .alarm_hour_hint   (alarm_hour_hint),
        .alarm_minute_hint (alarm_minute_hint),
        .awake_hint        (awake_hint)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: end the run if no beat moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (tick_ch.valid && tick_ch.ready) || (status_ch.valid && status_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Status receiver: random stalls, one long hold-off.
    initial
    begin
        int  taken;
        bit  held_off;
        taken    = 0;
        held_off = 1'b0;
        status_ch.ready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (status_ch.valid && status_ch.ready)
                taken = taken + 1;
            if (!held_off && taken >= HOLD_OFF_AT)
            begin
                held_off = 1'b1;
                status_ch.ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
            end
            else
                status_ch.ready <= steady || ($urandom_range(0, 99) >= 25);
        end
    end

    function automatic tick_t make_tick(input logic [BTN_W-1:0] btn, input int hour,
                                        input int minute, input logic wake);
        tick_t t;
        t.buttons    = btn;
        t.now_hour   = HOUR_W'(hour);
        t.now_minute = MIN_W'(minute);
        t.wake       = wake;
        return t;
    endfunction

    // Directed ticks: ringing while asleep, wake, menu keys and wraparound.
    function automatic tick_t directed_tick(input int i);
        int ah;
        int am;
        ah = int'(ALARM_HOUR_RST);
        am = int'(ALARM_MINUTE_RST);
        case (i)
            0:       return make_tick('0, 0, 0, 1'b0);
            1:       return make_tick('1, 31, 63, 1'b0);
            2:       return make_tick('0, ah, am, 1'b0);
            3:       return make_tick(B_MID, ah, am, 1'b0);
            4:       return make_tick('0, ah, am, 1'b0);
            5:       return make_tick('0, 31, 63, 1'b1);
            6:       return make_tick('0, 12, 34, 1'b1);
            7:       return make_tick(B_RIGHT, 12, 34, 1'b0);
            8:       return make_tick('0, 12, 34, 1'b0);
            9:       return make_tick(B_MID, 12, 34, 1'b0);
            10:      return make_tick(B_UP, 12, 34, 1'b0);
            11:      return make_tick(B_UP | B_DOWN, 12, 34, 1'b0);
            12:      return make_tick('0, 12, 34, 1'b0);
            13:      return make_tick(B_DOWN, 12, 35, 1'b0);
            14:      return make_tick(B_RIGHT | B_MID, 12, 35, 1'b0);
            15:      return make_tick('0, 12, 35, 1'b0);
            16:      return make_tick(B_DOWN, 12, 35, 1'b0);
            17:      return make_tick('0, 12, 35, 1'b0);
            18:      return make_tick(B_UP, 12, 35, 1'b0);
            19:      return make_tick(B_LEFT, 12, 35, 1'b0);
            20:      return make_tick(B_MID | B_LEFT, 12, 35, 1'b0);
            21:      return make_tick('0, 12, 35, 1'b0);
            22:      return make_tick(B_MID, 12, 35, 1'b0);
            default: return make_tick(B_LEFT, 12, 35, 1'b0);
        endcase
    endfunction

    // Random tick: buttons mostly held, time mostly steady or on the alarm.
    function automatic tick_t next_random_tick();
        tick_t t;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            t.buttons = cur_btn;
        else if (pick < 82)
            t.buttons = '0;
        else if (pick < 95)
            t.buttons = BTN_W'(1) << $urandom_range(0, BTN_W - 1);
        else
            t.buttons = BTN_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            t.now_hour   = cur_hour;
            t.now_minute = cur_min;
        end
        else if (pick < 80)
        begin
            t.now_hour   = alarm_hour_hint;
            t.now_minute = alarm_minute_hint;
        end
        else if (pick < 95)
        begin
            t.now_hour   = HOUR_W'($urandom_range(0, 23));
            t.now_minute = MIN_W'($urandom_range(0, 59));
        end
        else
        begin
            t.now_hour   = HOUR_W'($urandom);
            t.now_minute = MIN_W'($urandom);
        end
        t.wake   = awake_hint ? ($urandom_range(0, 99) < 3) : ($urandom_range(0, 99) < 15);
        cur_btn  = t.buttons;
        cur_hour = t.now_hour;
        cur_min  = t.now_minute;
        return t;
    endfunction

    // Offer one tick and hold it until the block takes the beat.
    task automatic send_tick(input tick_t t);
        tick_ch.valid      <= 1'b1;
        tick_ch.buttons    <= t.buttons;
        tick_ch.now_hour   <= t.now_hour;
        tick_ch.now_minute <= t.now_minute;
        tick_ch.wake       <= t.wake;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        ticks_sent = ticks_sent + 1;
    endtask

    task automatic idle_gap();
        while (!steady && $urandom_range(0, 99) < 25)
        begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stop offering and wait until every expected status beat has arrived.
    task automatic drain();
        tick_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic put_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    // Register settings of the random phases.
    task automatic load_setting(input int p);
        cfg_t s;
        case (p)
            0:       s = '{16'd3, 16'd1, 16'd30, 16'd2, 16'd4};
            1:       s = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
            2:       s = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
            3:       s = '{16'd1, 16'd0, 16'd120, 16'd1, 16'd1};
            5:       s = '{16'd6, 16'd2, 16'hFFFF, 16'hFFFF, 16'd0};
            6:       s = '{16'd0, 16'hFFFF, 16'd15, 16'd0, 16'hFFFF};
            default: s = '{CFG_W'($urandom_range(0, 12)), CFG_W'($urandom_range(0, 6)),
                           CFG_W'($urandom_range(0, 150)), CFG_W'($urandom_range(0, 8)),
                           CFG_W'($urandom_range(0, 8))};
        endcase
        put_reg(CFG_HOLD_TICKS, s.hold_ticks);
        put_reg(CFG_REPEAT_TICKS, s.repeat_ticks);
        put_reg(CFG_IDLE_TICKS, s.idle_ticks);
        put_reg(CFG_BLINK_TICKS, s.blink_ticks);
        put_reg(CFG_COLON_TICKS, s.colon_ticks);
        cfg_we <= 1'b0;
    endtask

    // Stimulus and verdict.
    initial
    begin
        tick_t t;
        int    i;
        int    p;
        int    useful;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_HOLD_TICKS;
        cfg_wdata          <= '0;
        steady             <= 1'b0;
        tick_ch.valid      <= 1'b0;
        tick_ch.buttons    <= '0;
        tick_ch.now_hour   <= '0;
        tick_ch.now_minute <= '0;
        tick_ch.wake       <= 1'b0;
        ticks_sent = 0;
        cur_btn    = '0;
        cur_hour   = HOUR_W'(12);
        cur_min    = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset register values.
        for (i = 0; i < 24; i++)
        begin
            send_tick(directed_tick(i));
            idle_gap();
        end
        drain();

        // Random phases, each under its own register setting.
        for (p = 0; p < PHASES; p++)
        begin
            load_setting(p);
            steady <= (p == 3);
            useful = 0;
            while (useful < PHASE_TICKS)
            begin
                t = next_random_tick();
                useful = useful + 1;
                send_tick(t);
                // Once mid-phase in phase 5, the sender waits for every result.
                if (p == 5 && useful == PHASE_TICKS / 2)
                    drain();
                else
                    idle_gap();
            end
            drain();
        end

        repeat (8) @(posedge clk);
        $display("Run covered %0d tick beats under nine register settings, %s",
                 ticks_sent, "from all zero to all maximum.");
        $display("%0d status beats compared, %0d of them with the alarm ringing.",
                 checked, ring_beats);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

>>> alarm_clock_setting_controller_unit.f
sv/acscu_pkg.sv
sv/acscu_in_if.sv
sv/acscu_out_if.sv
sv/acscu_cfg.sv
sv/acscu_in_stage.sv
sv/acscu_core.sv
sv/alarm_clock_setting_controller_unit.sv
dv/acscu_status_scoreboard.sv
dv/tb_alarm_clock_setting_controller_unit.sv
